[rtl/core/psrf_pkg.sv]
// ============================================================================
// psrf_pkg
// Shared types, widths and helpers for the short-range pair force pipeline.
// ============================================================================
package psrf_pkg;

    localparam int POS_W      = 24;
    localparam int MASS_W     = 32;
    localparam int FORCE_W    = 64;
    localparam int SQ_W       = 48;
    localparam int SOFT_W     = SQ_W + 1;
    localparam int K_W        = 3 * MASS_W;
    localparam int NUM_W      = K_W + POS_W;
    localparam int U_W        = 122;
    localparam int HEAD_W     = NUM_W + 8 - U_W;
    localparam int ROOT_W     = 32;
    localparam int SW_W       = POS_W + 1;
    localparam int DIV1_STEPS = U_W;
    localparam int DIV2_STEPS = FORCE_W;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int DIST_STEPS = POS_W;
    localparam int TERM_LAT   = DIV1_STEPS + DIV2_STEPS + 2;

    localparam logic [SW_W-1:0] ONE24 = SW_W'(1) << POS_W;

    typedef enum logic [2:0] {
        CFG_USE_MESH         = 3'd0,
        CFG_CUTOFF_SQ        = 3'd1,
        CFG_SWITCH_START_SQ  = 3'd2,
        CFG_SWITCH_START     = 3'd3,
        CFG_INV_SWITCH_WIDTH = 3'd4,
        CFG_MESH_SOFT_SQ     = 3'd5,
        CFG_DIRECT_SOFT_SQ   = 3'd6,
        CFG_GRAV_CONST       = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x_a;
        logic [POS_W-1:0]  pos_y_a;
        logic [POS_W-1:0]  pos_x_b;
        logic [POS_W-1:0]  pos_y_b;
        logic [MASS_W-1:0] mass_a;
        logic [MASS_W-1:0] mass_b;
    } in_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      in_range;
        logic                      saturated;
    } out_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sqrt_t;

    // one digit of the bitwise integer square root
    function automatic sqrt_t sqrt_step(input sqrt_t a, input logic [63:0] b);
        sqrt_t       o;
        logic [63:0] t;
        t = a.r + b;
        if (a.v >= t)
        begin
            o.v = a.v - t;
            o.r = (a.r >> 1) + b;
        end
        else
        begin
            o.v = a.v;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

endpackage

[rtl/core/psrf_term.sv]
// ============================================================================
// psrf_term
// One softened force term: floor(floor(num*2^8/s)*2^6/isqrt(s*2^14)),
// one quotient bit per stage.
// ============================================================================
module psrf_term
    import psrf_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [NUM_W-1:0]    num,
    input  logic [SOFT_W-1:0]   s,
    output logic [FORCE_W-1:0]  term,
    output logic                sat
);

    logic [SOFT_W-1:0]  dv1_reg  [0:DIV1_STEPS];
    logic [SOFT_W-1:0]  rem1_reg [0:DIV1_STEPS];
    logic [U_W-1:0]     nq1_reg  [0:DIV1_STEPS];
    logic               zero1_reg[0:DIV1_STEPS];
    logic               ovf1_reg [0:DIV1_STEPS];
    sqrt_t              sq_reg   [0:DIV1_STEPS];

    logic [ROOT_W-1:0]  dv2_reg  [0:DIV2_STEPS];
    logic [ROOT_W-1:0]  rem2_reg [0:DIV2_STEPS];
    logic [FORCE_W-1:0] nq2_reg  [0:DIV2_STEPS];
    logic               zero2_reg[0:DIV2_STEPS];
    logic               ovf2_reg [0:DIV2_STEPS];

    logic [SOFT_W-1:0]  head;
    logic [U_W-1:0]     u;
    logic [ROOT_W-1:0]  root;
    logic [FORCE_W-1:0] u_head;

    assign head = SOFT_W'(num[NUM_W-1 -: HEAD_W]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv1_reg[0]   <= s;
            rem1_reg[0]  <= head;
            nq1_reg[0]   <= {num[NUM_W-HEAD_W-1:0], 8'b0};
            zero1_reg[0] <= (s == '0);
            ovf1_reg[0]  <= (head >= s);
            sq_reg[0]    <= '{v: {1'b0, s, 14'b0}, r: 64'b0};
        end
    end

    for (genvar j = 0; j < DIV1_STEPS; j++)
    begin : g_div1
        logic [SOFT_W:0] trial;
        logic            ge;
        assign trial = {rem1_reg[j], nq1_reg[j][U_W-1]};
        assign ge    = (trial >= {1'b0, dv1_reg[j]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv1_reg[j+1]   <= dv1_reg[j];
                rem1_reg[j+1]  <= ge ? SOFT_W'(trial - {1'b0, dv1_reg[j]}) : SOFT_W'(trial);
                nq1_reg[j+1]   <= {nq1_reg[j][U_W-2:0], ge};
                zero1_reg[j+1] <= zero1_reg[j];
                ovf1_reg[j+1]  <= ovf1_reg[j];
            end
        end

        if (j < SQ_STEPS)
        begin : g_sq
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_reg[j+1] <= sqrt_step(sq_reg[j], 64'(1) << (62 - 2 * j));
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_reg[j+1] <= sq_reg[j];
                end
            end
        end
    end

    assign u      = nq1_reg[DIV1_STEPS];
    assign root   = sq_reg[DIV1_STEPS].r[ROOT_W-1:0];
    assign u_head = u[U_W-1 -: FORCE_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv2_reg[0]   <= root;
            rem2_reg[0]  <= u_head[ROOT_W-1:0];
            nq2_reg[0]   <= {u[U_W-FORCE_W-1:0], 6'b0};
            zero2_reg[0] <= zero1_reg[DIV1_STEPS];
            ovf2_reg[0]  <= ovf1_reg[DIV1_STEPS] || (u_head >= FORCE_W'(root));
        end
    end

    for (genvar j = 0; j < DIV2_STEPS; j++)
    begin : g_div2
        logic [ROOT_W:0] trial;
        logic            ge;
        assign trial = {rem2_reg[j], nq2_reg[j][FORCE_W-1]};
        assign ge    = (trial >= {1'b0, dv2_reg[j]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv2_reg[j+1]   <= dv2_reg[j];
                rem2_reg[j+1]  <= ge ? ROOT_W'(trial - {1'b0, dv2_reg[j]}) : ROOT_W'(trial);
                nq2_reg[j+1]   <= {nq2_reg[j][FORCE_W-2:0], ge};
                zero2_reg[j+1] <= zero2_reg[j];
                ovf2_reg[j+1]  <= ovf2_reg[j];
            end
        end
    end

    always_comb
    begin
        if (zero2_reg[DIV2_STEPS])
        begin
            term = '0;
            sat  = 1'b0;
        end
        else if (ovf2_reg[DIV2_STEPS])
        begin
            term = '1;
            sat  = 1'b1;
        end
        else
        begin
            term = nq2_reg[DIV2_STEPS];
            sat  = 1'b0;
        end
    end

endmodule

[rtl/core/pair_short_range_force_top.sv]
// ============================================================================
// pair_short_range_force_top
// Short-range pair force: wrapped separation, cutoff, smoothstep switch and
// softened direct minus mesh-scale force, saturated to Q8.55.
//
//   channel | signals                       | transaction
//   in      | in_valid/in_ready, in_data    | one particle pair
//   out     | out_valid/out_ready, out_data | force on the first particle
//   cfg     | cfg_valid/cfg_ready, cfg_*    | one register write
//
// One pair per cycle while the output is not stalled; the pipeline depth is set by
// the bit-per-stage dividers of the force terms (122 + 64 quotient bits).
// Reset clears valid bits and loads register defaults; cfg is always ready.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ============================================================================
module pair_short_range_force_top
    import psrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int PIPE_DEPTH = DIST_STEPS + TERM_LAT + 12;

    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [SQ_W-1:0]  r2;
        logic [POS_W-1:0] ax;
        logic [POS_W-1:0] ay;
        logic             nx;
        logic             ny;
        logic             far;
        logic             band;
    } carry_t;

    typedef struct packed {
        carry_t c;
        sqrt_t  sq;
    } geo_t;

    typedef struct packed {
        logic            nx;
        logic            ny;
        logic            far;
        logic [SW_W-1:0] sw;
    } side_t;

    typedef struct packed {
        logic [FORCE_W-1:0] f;
        logic               clamp;
    } fin_t;

    function automatic fin_t finish(input logic [FORCE_W+SW_W-1:0] sc, input logic neg);
        fin_t               o;
        logic [FORCE_W-1:0] m;
        logic [FORCE_W-1:0] lim;
        m       = sc[FORCE_W+POS_W-1:POS_W];
        lim     = neg ? (FORCE_W'(1) << (FORCE_W - 1)) : ((FORCE_W'(1) << (FORCE_W - 1)) - 1'b1);
        o.clamp = sc[FORCE_W+POS_W] || (m > lim);
        if (o.clamp)
        begin
            m = lim;
        end
        o.f = neg ? (FORCE_W'(0) - m) : m;
        return o;
    endfunction

    // configuration
    logic                use_mesh_reg;
    logic [SQ_W-1:0]     cutoff_sq_reg;
    logic [SQ_W-1:0]     switch_start_sq_reg;
    logic [POS_W-1:0]    switch_start_reg;
    logic [31:0]         inv_switch_width_reg;
    logic [SQ_W-1:0]     mesh_soft_sq_reg;
    logic [SQ_W-1:0]     direct_soft_sq_reg;
    logic [MASS_W-1:0]   grav_const_reg;

    logic                en;
    logic [PIPE_DEPTH-1:0] valid_reg;

    logic [POS_W-1:0]    dx;
    logic [POS_W-1:0]    dy;

    logic [POS_W-1:0]    p1_ax_reg, p1_ay_reg;
    logic                p1_nx_reg, p1_ny_reg;
    logic [63:0]         p1_gm_reg;
    logic [MASS_W-1:0]   p1_mb_reg;

    logic [POS_W-1:0]    p2_ax_reg, p2_ay_reg;
    logic                p2_nx_reg, p2_ny_reg;
    logic [SQ_W-1:0]     p2_r2_reg;
    logic [63:0]         p2_kl_reg, p2_kh_reg;

    geo_t                geo_reg [0:DIST_STEPS];
    geo_t                geo_next;
    logic [POS_W-1:0]    dist_root;

    logic [55:0]         p4_xm_reg;
    carry_t              p4_c_reg;
    logic [SW_W-1:0]     p5_x_reg;
    logic [49:0]         p5_x2p_reg;
    carry_t              p5_c_reg;
    logic [51:0]         p6_pp_reg;
    carry_t              p6_c_reg;

    logic [SW_W-1:0]     x_clamp;
    logic [25:0]         fac;
    logic [27:0]         p_val;
    logic [SW_W-1:0]     sw_next;

    logic [55:0]         p7_px_reg [0:2];
    logic [55:0]         p7_py_reg [0:2];
    logic [SOFT_W-1:0]   p7_sd_reg, p7_sm_reg;
    side_t               p7_side_reg;

    logic [NUM_W-1:0]    p8_numx_reg, p8_numy_reg;
    logic [SOFT_W-1:0]   p8_sd_reg, p8_sm_reg;
    side_t               side_reg [0:TERM_LAT];

    logic [FORCE_W-1:0]  t_dx, t_dy, t_mx, t_my;
    logic                s_dx, s_dy, s_mx, s_my;
    logic [FORCE_W-1:0]  tmx, tmy;
    logic                gtx, gty;

    logic [FORCE_W-1:0]  q1_magx_reg, q1_magy_reg;
    logic                q1_negx_reg, q1_negy_reg, q1_tsat_reg, q1_far_reg;
    logic [SW_W-1:0]     q1_sw_reg;

    logic [56:0]         q2_xl_reg, q2_xh_reg, q2_yl_reg, q2_yh_reg;
    logic                q2_negx_reg, q2_negy_reg, q2_tsat_reg, q2_far_reg;

    logic [FORCE_W+SW_W-1:0] q3_scx_reg, q3_scy_reg;
    logic                q3_negx_reg, q3_negy_reg, q3_tsat_reg, q3_far_reg;

    fin_t                fx, fy;
    out_t                out_reg;
    out_t                out_next;

    assign cfg_ready = 1'b1;
    assign en        = !valid_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_mesh_reg         <= 1'b1;
            cutoff_sq_reg        <= 48'd6871947673600;
            switch_start_sq_reg  <= 48'd4398046511104;
            switch_start_reg     <= 24'd2097152;
            inv_switch_width_reg <= 32'd536870912;
            mesh_soft_sq_reg     <= 48'd274877906944;
            direct_soft_sq_reg   <= 48'd45035996;
            grav_const_reg       <= 32'd227855092;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_USE_MESH:         use_mesh_reg         <= cfg_data[0];
                CFG_CUTOFF_SQ:        cutoff_sq_reg        <= cfg_data;
                CFG_SWITCH_START_SQ:  switch_start_sq_reg  <= cfg_data;
                CFG_SWITCH_START:     switch_start_reg     <= cfg_data[POS_W-1:0];
                CFG_INV_SWITCH_WIDTH: inv_switch_width_reg <= cfg_data[31:0];
                CFG_MESH_SOFT_SQ:     mesh_soft_sq_reg     <= cfg_data;
                CFG_DIRECT_SOFT_SQ:   direct_soft_sq_reg   <= cfg_data;
                CFG_GRAV_CONST:       grav_const_reg       <= cfg_data[31:0];
                default:              use_mesh_reg         <= use_mesh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // separation, wrapped to nearest image
    assign dx = in_data.pos_x_b - in_data.pos_x_a;
    assign dy = in_data.pos_y_b - in_data.pos_y_a;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ax_reg <= dx[POS_W-1] ? (POS_W'(0) - dx) : dx;
            p1_ay_reg <= dy[POS_W-1] ? (POS_W'(0) - dy) : dy;
            p1_nx_reg <= dx[POS_W-1];
            p1_ny_reg <= dy[POS_W-1];
            p1_gm_reg <= 64'(grav_const_reg) * 64'(in_data.mass_a);
            p1_mb_reg <= in_data.mass_b;

            p2_ax_reg <= p1_ax_reg;
            p2_ay_reg <= p1_ay_reg;
            p2_nx_reg <= p1_nx_reg;
            p2_ny_reg <= p1_ny_reg;
            p2_r2_reg <= SQ_W'(SQ_W'(p1_ax_reg) * SQ_W'(p1_ax_reg))
                       + SQ_W'(SQ_W'(p1_ay_reg) * SQ_W'(p1_ay_reg));
            p2_kl_reg <= 64'(p1_gm_reg[31:0]) * 64'(p1_mb_reg);
            p2_kh_reg <= 64'(p1_gm_reg[63:32]) * 64'(p1_mb_reg);

            geo_reg[0] <= geo_next;
        end
    end

    always_comb
    begin
        geo_next.c.k    = {p2_kh_reg, 32'b0} + K_W'(p2_kl_reg);
        geo_next.c.r2   = p2_r2_reg;
        geo_next.c.ax   = p2_ax_reg;
        geo_next.c.ay   = p2_ay_reg;
        geo_next.c.nx   = p2_nx_reg;
        geo_next.c.ny   = p2_ny_reg;
        geo_next.c.far  = use_mesh_reg && (p2_r2_reg > cutoff_sq_reg);
        geo_next.c.band = use_mesh_reg && (p2_r2_reg > switch_start_sq_reg);
        geo_next.sq.v   = 64'(p2_r2_reg);
        geo_next.sq.r   = 64'b0;
    end

    for (genvar j = 0; j < DIST_STEPS; j++)
    begin : g_dist
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                geo_reg[j+1].c  <= geo_reg[j].c;
                geo_reg[j+1].sq <= sqrt_step(geo_reg[j].sq, 64'(1) << (46 - 2 * j));
            end
        end
    end

    assign dist_root = geo_reg[DIST_STEPS].sq.r[POS_W-1:0];
    assign x_clamp   = (p4_xm_reg[55:24] > 32'(ONE24)) ? ONE24 : p4_xm_reg[48:24];
    assign fac       = 26'(3 * ONE24) - 26'({p5_x_reg, 1'b0});
    assign p_val     = p6_pp_reg[51:24];

    always_comb
    begin
        if (!p6_c_reg.band)
        begin
            sw_next = ONE24;
        end
        else if (p_val > 28'(ONE24))
        begin
            sw_next = '0;
        end
        else
        begin
            sw_next = ONE24 - SW_W'(p_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_xm_reg <= (dist_root > switch_start_reg)
                       ? 56'(dist_root - switch_start_reg) * 56'(inv_switch_width_reg)
                       : 56'b0;
            p4_c_reg  <= geo_reg[DIST_STEPS].c;

            p5_x_reg   <= x_clamp;
            p5_x2p_reg <= 50'(x_clamp) * 50'(x_clamp);
            p5_c_reg   <= p4_c_reg;

            p6_pp_reg <= 52'(p5_x2p_reg[49:24]) * 52'(fac);
            p6_c_reg  <= p5_c_reg;

            for (int i = 0; i < 3; i++)
            begin
                p7_px_reg[i] <= 56'(p6_c_reg.k[i*32 +: 32]) * 56'(p6_c_reg.ax);
                p7_py_reg[i] <= 56'(p6_c_reg.k[i*32 +: 32]) * 56'(p6_c_reg.ay);
            end
            p7_sd_reg      <= SOFT_W'(p6_c_reg.r2) + SOFT_W'(direct_soft_sq_reg);
            p7_sm_reg      <= SOFT_W'(p6_c_reg.r2) + SOFT_W'(mesh_soft_sq_reg);
            p7_side_reg.nx  <= p6_c_reg.nx;
            p7_side_reg.ny  <= p6_c_reg.ny;
            p7_side_reg.far <= p6_c_reg.far;
            p7_side_reg.sw  <= sw_next;

            p8_numx_reg <= NUM_W'(p7_px_reg[0]) + NUM_W'({p7_px_reg[1], 32'b0})
                         + {p7_px_reg[2], 64'b0};
            p8_numy_reg <= NUM_W'(p7_py_reg[0]) + NUM_W'({p7_py_reg[1], 32'b0})
                         + {p7_py_reg[2], 64'b0};
            p8_sd_reg   <= p7_sd_reg;
            p8_sm_reg   <= p7_sm_reg;
            side_reg[0] <= p7_side_reg;
        end
    end

    for (genvar j = 0; j < TERM_LAT; j++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    psrf_term u_term_dx (.clk(clk), .en(en), .num(p8_numx_reg), .s(p8_sd_reg),
                         .term(t_dx), .sat(s_dx));
    psrf_term u_term_mx (.clk(clk), .en(en), .num(p8_numx_reg), .s(p8_sm_reg),
                         .term(t_mx), .sat(s_mx));
    psrf_term u_term_dy (.clk(clk), .en(en), .num(p8_numy_reg), .s(p8_sd_reg),
                         .term(t_dy), .sat(s_dy));
    psrf_term u_term_my (.clk(clk), .en(en), .num(p8_numy_reg), .s(p8_sm_reg),
                         .term(t_my), .sat(s_my));

    assign tmx = use_mesh_reg ? t_mx : '0;
    assign tmy = use_mesh_reg ? t_my : '0;
    assign gtx = (tmx > t_dx);
    assign gty = (tmy > t_dy);

    assign fx = finish(q3_scx_reg, q3_negx_reg);
    assign fy = finish(q3_scy_reg, q3_negy_reg);

    always_comb
    begin
        if (q3_far_reg)
        begin
            out_next = '0;
        end
        else
        begin
            out_next.force_x   = fx.f;
            out_next.force_y   = fy.f;
            out_next.in_range  = 1'b1;
            out_next.saturated = q3_tsat_reg || fx.clamp || fy.clamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_magx_reg <= gtx ? (tmx - t_dx) : (t_dx - tmx);
            q1_magy_reg <= gty ? (tmy - t_dy) : (t_dy - tmy);
            q1_negx_reg <= side_reg[TERM_LAT].nx ^ gtx;
            q1_negy_reg <= side_reg[TERM_LAT].ny ^ gty;
            q1_tsat_reg <= s_dx || s_dy || (use_mesh_reg && (s_mx || s_my));
            q1_far_reg  <= side_reg[TERM_LAT].far;
            q1_sw_reg   <= side_reg[TERM_LAT].sw;

            q2_xl_reg   <= 57'(q1_magx_reg[31:0]) * 57'(q1_sw_reg);
            q2_xh_reg   <= 57'(q1_magx_reg[63:32]) * 57'(q1_sw_reg);
            q2_yl_reg   <= 57'(q1_magy_reg[31:0]) * 57'(q1_sw_reg);
            q2_yh_reg   <= 57'(q1_magy_reg[63:32]) * 57'(q1_sw_reg);
            q2_negx_reg <= q1_negx_reg;
            q2_negy_reg <= q1_negy_reg;
            q2_tsat_reg <= q1_tsat_reg;
            q2_far_reg  <= q1_far_reg;

            q3_scx_reg  <= {q2_xh_reg, 32'b0} + (FORCE_W+SW_W)'(q2_xl_reg);
            q3_scy_reg  <= {q2_yh_reg, 32'b0} + (FORCE_W+SW_W)'(q2_yl_reg);
            q3_negx_reg <= q2_negx_reg;
            q3_negy_reg <= q2_negy_reg;
            q3_tsat_reg <= q2_tsat_reg;
            q3_far_reg  <= q2_far_reg;

            out_reg     <= out_next;
        end
    end

endmodule
